FILE: hdl/rc_pkg.sv
// rc_pkg: shared types, constants and digit helpers for the radix converter.
// No dependencies; every other file but rc_ram refers to it by scoped name.

package rc_pkg;

  localparam int VALUE_W   = 63;  // format operand
  localparam int CHAR_W    = 7;   // ASCII character
  localparam int ACC_W     = 64;  // parse accumulator and divider word
  localparam int DIGIT_W   = 6;   // digit value, also base width
  localparam int CFG_IDX_W = 2;

  // long division: quotient bits resolved per cycle, passes per digit
  localparam int DIV_STEPS  = 8;
  localparam int DIV_PASSES = ACC_W / DIV_STEPS;
  localparam int PASS_W     = $clog2(DIV_PASSES);

  localparam logic [DIGIT_W-1:0] MIN_BASE   = 6'd2;
  localparam logic [DIGIT_W-1:0] RESET_BASE = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_0     = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_9     = 7'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_UA    = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UZ    = 7'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] LETTER_OFS = 7'h37;  // 'A' - 10

  typedef enum logic {
    ACT_FORMAT = 1'b0,
    ACT_PARSE  = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT_BASE = 2'd0,
    REG_PARSE_BASE  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT_RD,
    B_EMIT_WR
  } back_state_e;

  typedef struct packed {
    logic [DIGIT_W-1:0] format_base;
    logic [DIGIT_W-1:0] parse_base;
  } cfg_t;

  typedef struct packed {
    logic               bad;
    logic [DIGIT_W-1:0] value;
  } digit_t;

  // classified item as held in the queue
  typedef struct packed {
    action_e            action;
    logic [VALUE_W-1:0] value;
    logic [DIGIT_W-1:0] digit;
    logic               bad;
    logic               last;
  } item_t;

  function automatic logic [DIGIT_W-1:0] clamp_base(logic [DIGIT_W-1:0] b,
                                                    logic [DIGIT_W-1:0] asize);
    logic [DIGIT_W-1:0] r;
    r = b;
    if (b < MIN_BASE) begin
      r = MIN_BASE;
    end else if (b > asize) begin
      r = asize;
    end
    return r;
  endfunction

  // ASCII to digit value; anything outside the first asize letters is bad
  function automatic digit_t digit_of(logic [CHAR_W-1:0] c, logic [DIGIT_W-1:0] asize);
    logic [CHAR_W-1:0] v;
    digit_t            res;
    v   = '0;
    res = '{bad: 1'b1, value: '0};
    if (c >= CHAR_0 && c <= CHAR_9) begin
      v       = c - CHAR_0;
      res.bad = 1'b0;
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      v       = c - LETTER_OFS;
      res.bad = 1'b0;
    end
    if (!res.bad && v[DIGIT_W-1:0] >= asize) begin
      res.bad = 1'b1;
    end
    res.value = res.bad ? '0 : v[DIGIT_W-1:0];
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < 6'd10) begin
      r = CHAR_0 + {1'b0, d};
    end else begin
      r = LETTER_OFS + {1'b0, d};
    end
    return r;
  endfunction

endpackage

FILE: hdl/rc_if.sv
// rc_if: valid/ready channel interfaces of the radix converter (items in,
// results out, register writes). Depends on rc_pkg for field widths.

interface rc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [rc_pkg::VALUE_W-1:0] value_in;
  logic [rc_pkg::CHAR_W-1:0]  char_in;
  logic                       char_last;

  modport source (output valid, action, value_in, char_in, char_last, input ready);
  modport sink   (input valid, action, value_in, char_in, char_last, output ready);
endinterface

interface rc_out_if;
  logic                            valid;
  logic                            ready;
  logic [rc_pkg::CHAR_W-1:0]       char_out;
  logic signed [rc_pkg::ACC_W-1:0] value_out;
  logic                            is_parse_result;
  logic                            bad_char;
  logic                            run_last;

  modport source (output valid, char_out, value_out, is_parse_result, bad_char, run_last,
                  input ready);
  modport sink   (input valid, char_out, value_out, is_parse_result, bad_char, run_last,
                  output ready);
endinterface

interface rc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rc_pkg::CFG_IDX_W-1:0] index;
  logic [rc_pkg::DIGIT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/radix_converter.sv
// radix_converter: top level; base registers, front queue and back engine.
// Depends on rc_pkg, rc_if, rc_front, rc_back and rc_ram.

// Converts between binary and base-N digit text (alphabet 0-9A-Z, bases 2..36,
// out-of-range base registers clamp to 2 or ALPHABET_SIZE). A format item
// (action 0) yields its digit characters most significant first, run_last on
// the final one; zero gives '0'. A parse item (action 1) folds one character
// into a 64-bit wrapping accumulator and yields one result only when
// char_last is set; characters outside the alphabet count as zero and raise
// bad_char on that string's result. Items are taken into a two-entry queue,
// so up to two items can be held while the engine works or a result waits.
// A format item runs through the long divider, which resolves eight
// quotient bits a cycle over a 64-bit word for each digit; each buffered
// digit is then read back through the registered port of the digit
// buffer. Base 10 at most needs 19 digits, base 2 up to 63.
// Base registers are written through cfg_i (index 0 format base, index 1
// parse base, other indices ignored); write them only while the block is idle.

module radix_converter #(
  parameter int DIGIT_SLOTS   = 64,  // digit buffer depth, 64..128
  parameter int ALPHABET_SIZE = 36   // usable alphabet letters, 2..36
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc_cfg_if.sink    cfg_i,
  rc_in_if.sink     in_i,
  rc_out_if.source  out_o
);

  rc_pkg::cfg_t  cfg_q, cfg_d;
  logic          fr_head_valid;
  rc_pkg::item_t fr_head;
  logic          bk_pop;

  // base registers, always ready for a transfer
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (rc_pkg::cfg_reg_e'(cfg_i.index))
        rc_pkg::REG_FORMAT_BASE: cfg_d.format_base = cfg_i.data;
        rc_pkg::REG_PARSE_BASE:  cfg_d.parse_base  = cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{format_base: rc_pkg::RESET_BASE, parse_base: rc_pkg::RESET_BASE};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: character classification and item queue
  rc_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .head_valid_o (fr_head_valid),
    .head_o       (fr_head),
    .pop_i        (bk_pop)
  );

  // back: divider, digit buffer, accumulator, result register
  rc_back #(
    .DIGIT_SLOTS   (DIGIT_SLOTS),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (fr_head_valid),
    .head_i       (fr_head),
    .pop_o        (bk_pop),
    .out_o        (out_o)
  );

  // the engine only takes an item the queue really holds
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_pop |-> fr_head_valid)
    else $error("back popped an empty queue");

  // a full queue always presents a head item
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> fr_head_valid)
    else $error("input stalled with empty queue");

  // closing a string puts its parse result on the output next cycle
  a_parse_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_pop && fr_head.action == rc_pkg::ACT_PARSE && fr_head.last
    |=> out_o.valid && out_o.is_parse_result && out_o.run_last)
    else $error("finished string gave no parse result");

endmodule

FILE: hdl/rc_ram.sv
// rc_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.

module rc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/rc_front.sv
// rc_front: input side of the radix converter; classifies characters and
// buffers items in a two-entry queue. Depends on rc_pkg and rc_in_if.

module rc_front #(
  parameter int ALPHABET_SIZE = 36
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rc_in_if.sink         in_i,
  output logic          head_valid_o,
  output rc_pkg::item_t head_o,
  input  logic          pop_i
);

  localparam int QDEPTH = 2;  // power of two: pointers wrap naturally
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam logic [rc_pkg::DIGIT_W-1:0] ALPHA = rc_pkg::DIGIT_W'(ALPHABET_SIZE);

  rc_pkg::item_t  mem_q [QDEPTH];
  rc_pkg::item_t  item;
  rc_pkg::digit_t dg;
  logic [PW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push;

  // classify on the way in
  always_comb begin
    dg          = rc_pkg::digit_of(in_i.char_in, ALPHA);
    item.action = rc_pkg::action_e'(in_i.action);
    item.value  = in_i.value_in;
    item.digit  = dg.value;
    item.bad    = dg.bad;
    item.last   = in_i.char_last;
  end

  assign in_i.ready   = (cnt_q != CW'(QDEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = push  ? wptr_q + PW'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + PW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item;
    end
  end

endmodule

FILE: hdl/rc_back.sv
// rc_back: execution side of the radix converter; long-division digit
// generator, digit buffer, parse accumulator and result register.
// Depends on rc_pkg, rc_out_if and rc_ram.

module rc_back #(
  parameter int DIGIT_SLOTS   = 64,
  parameter int ALPHABET_SIZE = 36
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rc_pkg::cfg_t  cfg_i,
  input  logic          head_valid_i,
  input  rc_pkg::item_t head_i,
  output logic          pop_o,
  rc_out_if.source      out_o
);

  localparam int AW = $clog2(DIGIT_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DIGIT_SLOTS - 1);
  localparam logic [rc_pkg::PASS_W-1:0] PASS_LAST = rc_pkg::PASS_W'(rc_pkg::DIV_PASSES - 1);
  localparam logic [rc_pkg::DIGIT_W-1:0] ALPHA = rc_pkg::DIGIT_W'(ALPHABET_SIZE);

  localparam int ACC_W   = rc_pkg::ACC_W;
  localparam int DIGIT_W = rc_pkg::DIGIT_W;
  localparam int STEPS   = rc_pkg::DIV_STEPS;

  rc_pkg::back_state_e state_q, state_d;

  logic [ACC_W-1:0]          quo_q, quo_d, quo_next;
  logic [DIGIT_W-1:0]        rem_q, rem_d, rem_next;
  logic [rc_pkg::PASS_W-1:0] pass_q, pass_d;
  logic [DIGIT_W-1:0]        base_q, base_d;
  logic [AW-1:0]             wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ACC_W-1:0]          acc_q, acc_d, acc_new;
  logic                      started_q, started_d, bad_q, bad_d;
  logic [DIGIT_W-1:0]        pbase;
  logic [DIGIT_W-1:0]        rdata;

  logic                       out_valid_q, out_valid_d;
  logic [rc_pkg::CHAR_W-1:0]  out_char_q, out_char_d;
  logic [ACC_W-1:0]           out_value_q, out_value_d;
  logic                       out_parse_q, out_parse_d;
  logic                       out_bad_q, out_bad_d;
  logic                       out_last_q, out_last_d;
  logic                       out_free;

  // control strobes
  logic div_start, digit_done, prs_upd, ld_prs_out, ld_fmt_out;

  assign out_free = !out_valid_q || out_o.ready;

  // eight quotient bits per cycle, remainder stays below the base
  always_comb begin : div_chunk
    logic [DIGIT_W:0]   t;
    logic [DIGIT_W-1:0] r;
    logic [STEPS-1:0]   qbits;
    r     = rem_q;
    qbits = '0;
    for (int i = 0; i < STEPS; i++) begin
      t = {r, quo_q[ACC_W-1-i]};
      if (t >= {1'b0, base_q}) begin
        t                   = t - {1'b0, base_q};
        qbits[STEPS-1-i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
    quo_next = {quo_q[ACC_W-STEPS-1:0], qbits};
  end

  // parse step
  assign pbase   = rc_pkg::clamp_base(cfg_i.parse_base, ALPHA);
  assign acc_new = started_q
                 ? acc_q * {{(ACC_W-DIGIT_W){1'b0}}, pbase}
                   + {{(ACC_W-DIGIT_W){1'b0}}, head_i.digit}
                 : {{(ACC_W-DIGIT_W){1'b0}}, head_i.digit};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rc_pkg::B_IDLE: begin
        if (head_valid_i && head_i.action == rc_pkg::ACT_FORMAT) begin
          state_d = rc_pkg::B_DIV;
        end
      end
      rc_pkg::B_DIV: begin
        if (pass_q == PASS_LAST && (quo_next == '0 || wptr_q == LAST_SLOT)) begin
          state_d = rc_pkg::B_EMIT_RD;
        end
      end
      rc_pkg::B_EMIT_RD: begin
        state_d = rc_pkg::B_EMIT_WR;
      end
      rc_pkg::B_EMIT_WR: begin
        if (out_free) begin
          state_d = (rptr_q == '0) ? rc_pkg::B_IDLE : rc_pkg::B_EMIT_RD;
        end
      end
      default: begin
        state_d = rc_pkg::B_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    pop_o      = 1'b0;
    div_start  = 1'b0;
    digit_done = 1'b0;
    prs_upd    = 1'b0;
    ld_prs_out = 1'b0;
    ld_fmt_out = 1'b0;
    case (state_q)
      rc_pkg::B_IDLE: begin
        if (head_valid_i) begin
          if (head_i.action == rc_pkg::ACT_FORMAT) begin
            pop_o     = 1'b1;
            div_start = 1'b1;
          end else if (!head_i.last) begin
            pop_o   = 1'b1;
            prs_upd = 1'b1;
          end else if (out_free) begin
            pop_o      = 1'b1;
            prs_upd    = 1'b1;
            ld_prs_out = 1'b1;
          end
        end
      end
      rc_pkg::B_DIV: begin
        digit_done = (pass_q == PASS_LAST);
      end
      rc_pkg::B_EMIT_WR: begin
        ld_fmt_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    quo_d       = quo_q;
    rem_d       = rem_q;
    pass_d      = pass_q;
    base_d      = base_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    acc_d       = acc_q;
    started_d   = started_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_value_d = out_value_q;
    out_parse_d = out_parse_q;
    out_bad_d   = out_bad_q;
    out_last_d  = out_last_q;

    if (div_start) begin
      quo_d  = {1'b0, head_i.value};
      rem_d  = '0;
      pass_d = '0;
      wptr_d = '0;
      base_d = rc_pkg::clamp_base(cfg_i.format_base, ALPHA);
    end
    if (state_q == rc_pkg::B_DIV) begin
      quo_d  = quo_next;
      pass_d = pass_q + rc_pkg::PASS_W'(1);
      if (digit_done) begin
        rem_d  = '0;
        wptr_d = wptr_q + AW'(1);
        rptr_d = wptr_q;
      end else begin
        rem_d = rem_next;
      end
    end

    if (prs_upd) begin
      if (head_i.last) begin
        acc_d     = '0;
        started_d = 1'b0;
        bad_d     = 1'b0;
      end else begin
        acc_d     = acc_new;
        started_d = 1'b1;
        bad_d     = bad_q | head_i.bad;
      end
    end

    if (ld_prs_out) begin
      out_valid_d = 1'b1;
      out_char_d  = '0;
      out_value_d = acc_new;
      out_parse_d = 1'b1;
      out_bad_d   = bad_q | head_i.bad;
      out_last_d  = 1'b1;
    end else if (ld_fmt_out) begin
      out_valid_d = 1'b1;
      out_char_d  = rc_pkg::digit_char(rdata);
      out_value_d = '0;
      out_parse_d = 1'b0;
      out_bad_d   = 1'b0;
      out_last_d  = (rptr_q == '0);
      rptr_d      = rptr_q - AW'(1);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc_pkg::B_IDLE;
      pass_q      <= '0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      acc_q       <= '0;
      started_q   <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      acc_q       <= acc_d;
      started_q   <= started_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    base_q      <= base_d;
    out_char_q  <= out_char_d;
    out_value_q <= out_value_d;
    out_parse_q <= out_parse_d;
    out_bad_q   <= out_bad_d;
    out_last_q  <= out_last_d;
  end

  rc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_SLOTS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (digit_done),
    .waddr_i (wptr_q),
    .wdata_i (rem_next),
    .raddr_i (rptr_q),
    .rdata_o (rdata)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.char_out        = out_char_q;
  assign out_o.value_out       = $signed(out_value_q);
  assign out_o.is_parse_result = out_parse_q;
  assign out_o.bad_char        = out_bad_q;
  assign out_o.run_last        = out_last_q;

endmodule
